>>> sv/assert_macros.svh
// Assertion helpers for the RTL. They expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and codes shared by the positional list store and its cells.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [2:0] {
    KIND_APPEND       = 3'd0,
    KIND_INSERT       = 3'd1,
    KIND_DELETE       = 3'd2,
    KIND_DELETE_FIRST = 3'd3,
    KIND_FIND         = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_MATCH,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

>>> sv/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds an entry and a match flag, and trades both with its
// neighbors when the list opens a gap, closes one, or scans for a match.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int INDEX    = 0,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [IW-1:0]      sel_idx,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  input  logic               right_match,
  output logic signed [31:0] data,
  output logic               match
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (MY_IDX > sel_idx) begin
          data <= left_data;
        end else if (MY_IDX == sel_idx) begin
          data <= ctl.value;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= sel_idx) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // match flags walk toward the head one slot per cycle during a scan
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_MATCH: match <= (data == ctl.value) && (MY_CNT < count);
      CELL_SCAN:  match <= right_match;
      default: begin
      end
    endcase
  end

endmodule

>>> sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to CAPACITY signed 32-bit entries with 1-based positions.
// ----------------------------------------------------------------------------
// Append, insert, delete and delete-first need no scan: cells from the
// chosen slot on move entries to or from a neighbor in parallel, and the
// result is registered for the next cycle. For a find, all cells compare at
// once (an empty list skips the scan), then the match flags shift one cell
// per cycle toward the head, where a counter tracks the position, until the
// head flag is set or the counter reaches the entry count. A new request is
// taken as soon as the output register is free or is being emptied in the
// same cycle, and no find is scanning.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic signed [31:0] item_value,
  input  logic [4:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [4:0]         found_position,
  output logic [4:0]         entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   scan_pos;
  cell_ctl_t       ctl;
  logic            accept;
  logic            scan_hit, scan_done;
  status_t         dec_status;
  cell_op_t        dec_op;
  logic [IW-1:0]   dec_idx;
  logic            dec_scan;
  logic [PW-1:0]   pos_ext, cnt_ext;

  logic signed [31:0] cell_data  [CAPACITY];
  logic               cell_match [CAPACITY];

  assign pos_ext   = PW'(position);
  assign cnt_ext   = PW'(count);
  assign accept    = in_valid && !in_stall;
  assign scan_hit  = cell_match[0];
  assign scan_done = scan_hit || (scan_pos >= count);

  // request decode
  always_comb begin
    dec_status = ST_DONE;
    dec_op     = CELL_HOLD;
    dec_idx    = '0;
    dec_scan   = 1'b0;
    case (kind)
      KIND_APPEND: begin
        if (count == FULL_CNT) begin
          dec_status = ST_FULL;
        end else begin
          dec_op  = CELL_INSERT;
          dec_idx = IW'(count);
        end
      end
      KIND_INSERT: begin
        if (position == 5'd0 || pos_ext > cnt_ext + PW'(1)) begin
          dec_status = ST_RANGE;
        end else if (count == FULL_CNT) begin
          dec_status = ST_FULL;
        end else begin
          dec_op  = CELL_INSERT;
          dec_idx = IW'(position - 5'd1);
        end
      end
      KIND_DELETE: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else if (position == 5'd0 || pos_ext > cnt_ext) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op  = CELL_REMOVE;
          dec_idx = IW'(position - 5'd1);
        end
      end
      KIND_DELETE_FIRST: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_op = CELL_REMOVE;
        end
      end
      KIND_FIND: begin
        dec_op   = CELL_MATCH;
        dec_scan = (count != '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (dec_op)
      CELL_INSERT: count_next = count + CW'(1);
      CELL_REMOVE: count_next = count - CW'(1);
      default:     count_next = count;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && dec_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall  = 1'b1;
    ctl.op    = CELL_HOLD;
    ctl.value = item_value;
    case (state)
      S_IDLE: begin
        in_stall = out_valid && out_stall;
        if (accept) begin
          ctl.op = dec_op;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          ctl.op = CELL_SCAN;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    logic               right_m;
    if (i == 0) begin : g_head
      assign left_d = 32'sd0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = 32'sd0;
      assign right_m = 1'b0;
    end else begin : g_body
      assign right_d = cell_data[i+1];
      assign right_m = cell_match[i+1];
    end
    pls_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .sel_idx     (dec_idx),
      .count       (count),
      .left_data   (left_d),
      .right_data  (right_d),
      .right_match (right_m),
      .data        (cell_data[i]),
      .match       (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        count <= count_next;
        if (!dec_scan) begin
          out_valid <= 1'b1;
        end
      end
      if (state == S_SCAN && scan_done) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_pos       <= CW'(1);
      status         <= dec_status;
      found_position <= 5'd0;
      entry_count    <= 5'(count_next);
    end else if (state == S_SCAN) begin
      if (scan_done) begin
        status         <= ST_DONE;
        found_position <= scan_hit ? 5'(scan_pos) : 5'd0;
        entry_count    <= 5'(count);
      end else begin
        scan_pos <= scan_pos + CW'(1);
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_count_bound, count > FULL_CNT, "entry count above capacity")
  `ASSERT_CLK(a_scan_no_result, state == S_SCAN |-> !out_valid, "result pending during scan")
  `ASSERT_CLK(a_scan_pos, state == S_SCAN |-> scan_pos != '0 && scan_pos <= count, "scan past list")
  `ASSERT_CLK(a_scan_stall, state == S_SCAN |-> in_stall, "request taken during scan")

endmodule

>>> sim/positional_list_store_tb.sv
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Drives list operations through the request channel with random gaps and
// output stalls. A scoreboard keeps its own copy of the list, predicts the
// status, match position and entry count of every request, and compares each
// result in order.
// ----------------------------------------------------------------------------
module positional_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pls_pkg::*;

  localparam int DEPTH = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    status_t    st;
    logic [4:0] found_pos;
    logic [4:0] fill;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] vals [DEPTH];
    int fill;
    list_result_t pending [$];
    int errors, n_requests, n_results, n_full, n_empty, n_range, n_hits, peak;

    function new();
      fill = 0;
      errors = 0;
      n_requests = 0;
      n_results = 0;
      n_full = 0;
      n_empty = 0;
      n_range = 0;
      n_hits = 0;
      peak = 0;
    endfunction

    // Applies one accepted request to the shadow list and queues its result.
    function void note_request(logic [2:0] k, logic signed [31:0] v, logic [4:0] p);
      list_result_t r;
      int pi;
      int i;
      pi = int'(p);
      r.st = ST_DONE;
      r.found_pos = '0;
      case (k)
        KIND_APPEND: begin
          if (fill >= DEPTH) r.st = ST_FULL;
          else begin
            vals[fill] = v;
            fill++;
          end
        end
        KIND_INSERT: begin
          // range is checked before fullness
          if (pi < 1 || pi > fill + 1) r.st = ST_RANGE;
          else if (fill >= DEPTH) r.st = ST_FULL;
          else begin
            for (i = fill; i > pi - 1; i--) vals[i] = vals[i - 1];
            vals[pi - 1] = v;
            fill++;
          end
        end
        KIND_DELETE: begin
          // emptiness is checked before the range
          if (fill == 0) r.st = ST_EMPTY;
          else if (pi < 1 || pi > fill) r.st = ST_RANGE;
          else begin
            for (i = pi - 1; i < fill - 1; i++) vals[i] = vals[i + 1];
            fill--;
          end
        end
        KIND_DELETE_FIRST: begin
          if (fill == 0) r.st = ST_EMPTY;
          else begin
            for (i = 0; i < fill - 1; i++) vals[i] = vals[i + 1];
            fill--;
          end
        end
        KIND_FIND: begin
          for (i = 0; i < fill; i++) begin
            if (vals[i] == v) begin
              r.found_pos = 5'(i + 1);
              break;
            end
          end
        end
        default: ;
      endcase
      r.fill = fill[4:0];
      case (r.st)
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        ST_RANGE: n_range++;
        default:  ;
      endcase
      if (r.found_pos != 0) n_hits++;
      if (fill > peak) peak = fill;
      n_requests++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [4:0] fp, logic [4:0] cnt);
      list_result_t e;
      n_results++;
      if (pending.size() == 0) begin
        $error("result with no request pending: status %0d, count %0d", st, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (fp !== e.found_pos) begin
        $error("found_position: expected %0d, got %0d", e.found_pos, fp);
        errors++;
      end
      if (cnt !== e.fill) begin
        $error("entry_count: expected %0d, got %0d", e.fill, cnt);
        errors++;
      end
    endfunction

    // A value already in the list, so that finds and duplicates happen often (a random one when the list is empty).
    function logic signed [31:0] pick_value();
      if (fill > 0) return vals[$urandom_range(0, fill - 1)];
      return $urandom;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         kind = '0;
  logic signed [31:0] item_value = '0;
  logic [4:0]         position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [4:0]         found_position;
  logic [4:0]         entry_count;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  list_scoreboard sb;

  positional_list_store dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .item_value     (item_value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, found_position, entry_count);
  end

  // Receiver: after each result, raises out_stall at random to hold off the next one.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = recv_idle ? $urandom_range(0, 3) : 0;
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_request(input logic [2:0] k, input logic signed [31:0] v,
                              input logic [4:0] p);
    int gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    item_value <= v;
    position <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(k, v, p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed requests with positions in range; a few raw ones.
  task automatic random_request(input bit grow, output bit useful);
    int roll;
    logic [2:0] k;
    logic signed [31:0] v;
    logic [4:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      k = 3'($urandom_range(0, 7));
      v = $urandom;
      p = 5'($urandom_range(0, 31));
    end else begin
      roll = $urandom_range(0, 99);
      if (grow)
        k = roll < 35 ? KIND_APPEND : roll < 65 ? KIND_INSERT : roll < 75 ? KIND_DELETE :
            roll < 80 ? KIND_DELETE_FIRST : KIND_FIND;
      else
        k = roll < 10 ? KIND_APPEND : roll < 20 ? KIND_INSERT : roll < 50 ? KIND_DELETE :
            roll < 70 ? KIND_DELETE_FIRST : KIND_FIND;
      case ($urandom_range(0, 3))
        0: v = sb.pick_value();
        1: v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        2: v = $signed($urandom_range(0, 8)) - 4;
        default: v = $urandom;
      endcase
      if (k == KIND_DELETE) p = sb.fill > 0 ? 5'($urandom_range(1, sb.fill)) : 5'd1;
      else p = 5'($urandom_range(1, sb.fill + 1));
    end
    useful = (k <= KIND_FIND);
    send_request(k, v, p);
  endtask

  initial begin
    int issued;
    int phase;
    int len;
    bit useful;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corners
    send_request(KIND_DELETE, 0, 1);
    send_request(KIND_DELETE_FIRST, 0, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_INSERT, 1, 0);
    send_request(KIND_INSERT, 2, 2);
    // build a short list with extreme values, insert at end and middle
    send_request(KIND_INSERT, 32'sh8000_0000, 1);
    send_request(KIND_APPEND, 32'sh7fff_ffff, 31);
    send_request(KIND_APPEND, -1, 0);
    send_request(KIND_INSERT, 0, 4);
    send_request(KIND_INSERT, 5, 2);
    send_request(KIND_FIND, -1, 0);
    send_request(KIND_FIND, 12345, 0);
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_DELETE, 0, 6);
    send_request(KIND_DELETE, 0, 3);
    send_request(KIND_DELETE, 0, 4);
    send_request(KIND_DELETE_FIRST, 0, 0);
    send_request(KIND_SPARE_LO, -1, 31);
    send_request(KIND_SPARE_HI, 0, 31);
    while (sb.fill < DEPTH)
      send_request(KIND_INSERT, $urandom, 5'($urandom_range(1, sb.fill + 1)));
    // full list corners
    send_request(KIND_APPEND, 7, 0);
    send_request(KIND_INSERT, 7, 17);
    send_request(KIND_INSERT, 7, 16);
    send_request(KIND_INSERT, 7, 31);
    send_request(KIND_FIND, sb.vals[DEPTH - 1], 0);
    send_request(KIND_DELETE, 0, 16);
    send_request(KIND_DELETE, 0, 16);
    wait_drained();

    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      len = $urandom_range(40, 160);
      send_idle = (phase % 5) != 3;
      recv_idle = (phase % 4) != 2;
      repeat (len) begin
        random_request(phase % 2 == 0, useful);
        if (useful) issued++;
      end
      if (phase % 3 == 1) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d results; the list held up to %0d entries.",
             sb.n_requests, sb.n_results, sb.peak);
    $display("Rejected: %0d full, %0d empty, %0d out of range; %0d finds hit an entry.",
             sb.n_full, sb.n_empty, sb.n_range, sb.n_hits);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> positional_list_store.f
+incdir+sv
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_store.sv
sim/positional_list_store_tb.sv
